@@ rtl/sle_pkg.sv @@
// sle_pkg: shared constants, operation codes and the queued command record
// for the list engine. No dependencies.
package sle_pkg;

  localparam int DEPTH  = 128;
  localparam int ELEM_W = 32;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_DEL_VAL = 3'd1,
    OP_DEL_POS = 3'd2,
    OP_DEDUP   = 3'd3,
    OP_REV     = 3'd4,
    OP_ROT     = 3'd5,
    OP_READ    = 3'd6,
    OP_BAD     = 3'd7
  } op_e;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] value;
    logic [7:0]         position;
    logic signed [15:0] shift;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmdq_t;

endpackage

@@ rtl/sle_front.sv @@
// sle_front: accepts command items, decodes the operation and holds them
// in a two-entry queue for the back end. Depends on sle_pkg.
module sle_front import sle_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         command_i,
  input  logic signed [31:0] value_i,
  input  logic [7:0]         position_i,
  input  logic signed [15:0] shift_i,
  output cmdq_t              head_o,
  input  logic               pop_i
);

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  cmd_t       dec;

  always_comb begin
    dec.value    = value_i;
    dec.position = position_i;
    dec.shift    = shift_i;
    unique case (command_i)
      3'd0:    dec.op = OP_APPEND;
      3'd1:    dec.op = OP_DEL_VAL;
      3'd2:    dec.op = OP_DEL_POS;
      3'd3:    dec.op = OP_DEDUP;
      3'd4:    dec.op = OP_REV;
      3'd5:    dec.op = OP_ROT;
      3'd6:    dec.op = OP_READ;
      default: dec.op = OP_BAD;
    endcase
  end

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cmd   = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ rtl/sle_back.sv @@
// sle_back: executes list commands on the element memory and holds the
// result register. Depends on sle_pkg.
module sle_back import sle_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmdq_t              head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               status_o,
  output logic [7:0]         element_count_o,
  output logic signed [31:0] read_value_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_REV  = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;

  localparam logic [1:0] RP_RD  = 2'd0;
  localparam logic [1:0] RP_WLO = 2'd1;
  localparam logic [1:0] RP_WHI = 2'd2;

  localparam int MAG_W = 17;

  logic [ELEM_W-1:0] mem [DEPTH];
  logic [ELEM_W-1:0] rdata_a_q, rdata_b_q;
  logic [AW-1:0]     rd_a, rd_b, waddr;
  logic              rd_en, we;
  logic [ELEM_W-1:0] wdata;

  logic [2:0]  state_q, state_d;
  logic [1:0]  ph_q, ph_d;
  logic [1:0]  seg_q, seg_d;
  cmd_t        cmd_q, cmd_d;
  logic [CW-1:0] len_q, len_d;
  logic [CW-1:0] i_q, i_d, idx_q, idx_d, w_q, w_d;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, k_q, k_d;
  logic          vld_q, vld_d, hit_q, hit_d;
  logic [ELEM_W-1:0] last_q, last_d;
  logic [MAG_W-1:0]  mag_q, mag_d;
  logic [CW-1:0]     rem_q, rem_d;
  logic [4:0]        step_q, step_d;
  logic              neg_q, neg_d;

  logic              out_valid_q, out_valid_d;
  logic              status_q, status_d;
  logic [7:0]        count_q, count_d;
  logic [31:0]       rval_q, rval_d;

  logic              out_free, skip;
  logic [CW-1:0]     rem_sh, rem_new, k_new, pos_m1;
  logic [MAG_W-1:0]  sh_ext;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = head_i.valid && (state_q == S_IDLE) && out_free;
  assign pos_m1   = cmd_q.position - 8'd1;
  assign sh_ext   = {head_i.cmd.shift[15], head_i.cmd.shift};

  // remainder step of the rotation amount, one bit a cycle
  assign rem_sh  = {rem_q[CW-2:0], mag_q[MAG_W-1]};
  assign rem_new = (rem_sh >= len_q) ? rem_sh - len_q : rem_sh;
  assign k_new   = (neg_q && rem_new != '0) ? len_q - rem_new : rem_new;

  always_comb begin
    unique case (cmd_q.op)
      OP_DEL_VAL: skip = (rdata_a_q == cmd_q.value);
      OP_DEL_POS: skip = (idx_q == pos_m1);
      default:    skip = (idx_q != '0) && (rdata_a_q == last_q);
    endcase
  end

  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    seg_d   = seg_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    i_d     = i_q;
    idx_d   = idx_q;
    w_d     = w_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    k_d     = k_q;
    vld_d   = 1'b0;
    hit_d   = hit_q;
    last_d  = last_q;
    mag_d   = mag_q;
    rem_d   = rem_q;
    step_d  = step_q;
    neg_d   = neg_q;
    rd_en   = 1'b0;
    rd_a    = lo_q[AW-1:0];
    rd_b    = hi_q[AW-1:0];
    we      = 1'b0;
    waddr   = w_q[AW-1:0];
    wdata   = rdata_a_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    count_d     = count_q;
    rval_d      = rval_q;

    unique case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          cmd_d    = head_i.cmd;
          i_d      = '0;
          w_d      = '0;
          hit_d    = 1'b0;
          lo_d     = '0;
          hi_d     = len_q - 1'b1;
          ph_d     = RP_RD;
          seg_d    = 2'd0;
          status_d = 1'b0;
          count_d  = len_q;
          rval_d   = '0;
          unique case (head_i.cmd.op)
            OP_APPEND: begin
              out_valid_d = 1'b1;
              if (len_q >= CW'(DEPTH)) begin
                status_d = 1'b1;
              end else begin
                we      = 1'b1;
                waddr   = len_q[AW-1:0];
                wdata   = head_i.cmd.value;
                len_d   = len_q + 1'b1;
                count_d = len_q + 1'b1;
              end
            end
            OP_DEL_VAL: state_d = S_CMP;
            OP_DEL_POS: begin
              if (len_q == '0 || head_i.cmd.position == 8'd0 ||
                  head_i.cmd.position > len_q) begin
                out_valid_d = 1'b1;
                status_d    = 1'b1;
              end else begin
                state_d = S_CMP;
              end
            end
            OP_DEDUP: begin
              if (len_q == '0) begin
                out_valid_d = 1'b1;
                status_d    = 1'b1;
              end else begin
                state_d = S_CMP;
              end
            end
            OP_REV: begin
              if (len_q < CW'(2)) begin
                out_valid_d = 1'b1;
              end else begin
                state_d = S_REV;
              end
            end
            OP_ROT: begin
              if (len_q == '0) begin
                out_valid_d = 1'b1;
                status_d    = 1'b1;
              end else begin
                neg_d   = head_i.cmd.shift[15];
                mag_d   = head_i.cmd.shift[15] ? -sh_ext : sh_ext;
                rem_d   = '0;
                step_d  = '0;
                state_d = S_MOD;
              end
            end
            OP_READ: begin
              if (head_i.cmd.position == 8'd0 || head_i.cmd.position > len_q) begin
                out_valid_d = 1'b1;
                status_d    = 1'b1;
              end else begin
                rd_en   = 1'b1;
                rd_a    = AW'(head_i.cmd.position - 8'd1);
                state_d = S_RD;
              end
            end
            default: begin
              out_valid_d = 1'b1;
              status_d    = 1'b1;
            end
          endcase
        end
      end

      S_RD: begin
        out_valid_d = 1'b1;
        rval_d      = rdata_a_q;
        state_d     = S_IDLE;
      end

      S_CMP: begin
        // issue one read and retire the previous one each cycle
        if (i_q < len_q) begin
          rd_en = 1'b1;
          rd_a  = i_q[AW-1:0];
          i_d   = i_q + 1'b1;
          idx_d = i_q;
          vld_d = 1'b1;
        end
        if (vld_q) begin
          if (skip) begin
            hit_d = 1'b1;
          end else begin
            we     = 1'b1;
            waddr  = w_q[AW-1:0];
            wdata  = rdata_a_q;
            w_d    = w_q + 1'b1;
            last_d = rdata_a_q;
          end
        end else if (i_q >= len_q) begin
          len_d       = w_q;
          count_d     = w_q;
          status_d    = !hit_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_MOD: begin
        rem_d  = rem_new;
        mag_d  = {mag_q[MAG_W-2:0], 1'b0};
        step_d = step_q + 1'b1;
        if (step_q == 5'(MAG_W - 1)) begin
          k_d = k_new;
          if (k_new == '0) begin
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end else begin
            lo_d    = '0;
            hi_d    = len_q - 1'b1;
            ph_d    = RP_RD;
            seg_d   = 2'd0;
            state_d = S_REV;
          end
        end
      end

      S_REV: begin
        // reverse all; for a rotation right by k, then also the first k, then the rest
        unique case (ph_q)
          RP_RD: begin
            if (lo_q < hi_q) begin
              rd_en = 1'b1;
              ph_d  = RP_WLO;
            end else if (cmd_q.op == OP_ROT && seg_q == 2'd0) begin
              seg_d = 2'd1;
              lo_d  = '0;
              hi_d  = k_q - 1'b1;
            end else if (cmd_q.op == OP_ROT && seg_q == 2'd1) begin
              seg_d = 2'd2;
              lo_d  = k_q;
              hi_d  = len_q - 1'b1;
            end else begin
              out_valid_d = 1'b1;
              state_d     = S_IDLE;
            end
          end
          RP_WLO: begin
            we    = 1'b1;
            waddr = lo_q[AW-1:0];
            wdata = rdata_b_q;
            ph_d  = RP_WHI;
          end
          default: begin
            we    = 1'b1;
            waddr = hi_q[AW-1:0];
            wdata = rdata_a_q;
            lo_d  = lo_q + 1'b1;
            hi_d  = hi_q - 1'b1;
            ph_d  = RP_RD;
          end
        endcase
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_a_q <= mem[rd_a];
      rdata_b_q <= mem[rd_b];
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    i_q    <= i_d;
    idx_q  <= idx_d;
    w_q    <= w_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    k_q    <= k_d;
    hit_q  <= hit_d;
    last_q <= last_d;
    mag_q  <= mag_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    neg_q  <= neg_d;
    ph_q   <= ph_d;
    seg_q  <= seg_d;
    status_q <= status_d;
    count_q  <= count_d;
    rval_q   <= rval_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      vld_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign element_count_o = count_q;
  assign read_value_o    = rval_q;

endmodule

@@ rtl/sequential_list_engine.sv @@
// sequential_list_engine: top level, a command queue front end feeding the
// list execution back end. Depends on sle_pkg, sle_front and sle_back.
//
// Usage: a command item enters on in_valid_i/in_stall_o with command_i,
// value_i, position_i and shift_i. Each item gives exactly one result item on
// out_valid_o/out_stall_i carrying status_o, element_count_o and read_value_o.
// Items are taken when valid is high and stall is low on that channel.
// The front end queues up to two commands, so items are accepted while the
// back end works or while a result waits in the output register.
// A rotate first reduces the shift modulo the length in remainder steps,
// then, for a nonzero amount, performs three in-place reversals.
// The back end executes one command at a time on the single-write-port
// element memory. A result held by out_stall_i keeps the back end from
// starting the next command; the queue then fills and in_stall_o rises.
// Reset empties the queue and the output register and sets the length to
// zero; memory contents are not cleared.
module sequential_list_engine import sle_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         command_i,
  input  logic signed [31:0] value_i,
  input  logic [7:0]         position_i,
  input  logic signed [15:0] shift_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               status_o,
  output logic [7:0]         element_count_o,
  output logic signed [31:0] read_value_o
);

  cmdq_t head;
  logic  pop;

  sle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .value_i    (value_i),
    .position_i (position_i),
    .shift_i    (shift_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  sle_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .element_count_o (element_count_o),
    .read_value_o    (read_value_o)
  );

endmodule

@@ verif/tb.sv @@
// tb: self-checking bench for sequential_list_engine, a directed table then
// weighted random commands checked against a behavioral list model.
// Depends on sle_pkg and the sequential_list_engine rtl.
module tb import sle_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        status;
    logic [7:0]  count;
    logic [31:0] rdval;
  } list_result_t;

  typedef struct {
    op_e         op;
    logic [31:0] value;
    logic [7:0]  position;
    logic [15:0] shift;
    bit          known;
    logic        status;
    logic [7:0]  count;
    logic [31:0] rdval;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         command_i = '0;
  logic signed [31:0] value_i = '0;
  logic [7:0]         position_i = '0;
  logic signed [15:0] shift_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               status_o;
  logic [7:0]         element_count_o;
  logic signed [31:0] read_value_o;

  logic signed [31:0] model_words[DEPTH];
  int unsigned        model_len;
  list_result_t       pending_results[$];
  int                 errors;
  int                 sent;
  int                 checked;
  int                 full_hits;
  int                 dedup_sets;
  bit                 quiet;
  bit                 hold_done;
  bit                 drain_done;

  sequential_list_engine dut (.*);

  always #1 clk_i = ~clk_i;

  // list model, applied when a command item is accepted
  function automatic list_result_t apply_command(op_e op, logic signed [31:0] v,
                                                 logic [7:0] p, logic signed [15:0] s);
    list_result_t       r;
    logic signed [31:0] tmp[DEPTH];
    int unsigned        w;
    bit                 hit;
    int                 k;
    r = '{1'b0, 8'd0, 32'd0};
    case (op)
      OP_APPEND: begin
        if (model_len >= DEPTH) r.status = 1'b1;
        else begin
          model_words[model_len] = v;
          model_len++;
        end
      end
      OP_DEL_VAL: begin
        hit = 0;
        w = 0;
        for (int i = 0; i < model_len; i++)
          if (model_words[i] == v) hit = 1;
          else model_words[w++] = model_words[i];
        r.status = !hit;
        model_len = w;
      end
      OP_DEL_POS: begin
        if (p == 0 || p > model_len) r.status = 1'b1;
        else begin
          for (int i = p - 1; i + 1 < model_len; i++) model_words[i] = model_words[i + 1];
          model_len--;
        end
      end
      OP_DEDUP: begin
        if (model_len == 0) r.status = 1'b1;
        else begin
          hit = 0;
          w = 1;
          for (int i = 1; i < model_len; i++)
            if (model_words[i] == model_words[w - 1]) hit = 1;
            else model_words[w++] = model_words[i];
          r.status = !hit;
          model_len = w;
        end
      end
      OP_REV: begin
        for (int i = 0; i < model_len / 2; i++) begin
          tmp[0] = model_words[i];
          model_words[i] = model_words[model_len - 1 - i];
          model_words[model_len - 1 - i] = tmp[0];
        end
      end
      OP_ROT: begin
        if (model_len == 0) r.status = 1'b1;
        else begin
          k = int'(s) % int'(model_len);
          if (k < 0) k += model_len;
          for (int i = 0; i < model_len; i++) tmp[(i + k) % model_len] = model_words[i];
          for (int i = 0; i < model_len; i++) model_words[i] = tmp[i];
        end
      end
      OP_READ: begin
        if (p == 0 || p > model_len) r.status = 1'b1;
        else r.rdval = model_words[p - 1];
      end
      default: r.status = 1'b1;
    endcase
    r.count = model_len[7:0];
    return r;
  endfunction

  // offers one item, waits for acceptance, then records the expected result
  task automatic send_cmd(op_e op, logic [31:0] v, logic [7:0] p, logic [15:0] s,
                          bit known = 0, list_result_t given = '{1'b0, 8'd0, 32'd0});
    list_result_t r;
    if (!quiet && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= op;
    value_i    <= v;
    position_i <= p;
    shift_i    <= s;
    do @(posedge clk_i); while (in_stall_o);
    r = apply_command(op, v, p, s);
    if (op == OP_APPEND && r.status) full_hits++;
    pending_results.push_back(known ? given : r);
    sent++;
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom_range(9) - 5;
    endcase
  endfunction

  function automatic logic [7:0] pick_position();
    if ($urandom_range(9) == 0) return $urandom_range(255);
    return $urandom_range(model_len + 1);
  endfunction

  function automatic logic [15:0] pick_shift();
    if ($urandom_range(2) == 0) return $urandom;
    return $urandom_range(20) - 10;
  endfunction

  // empty the list, build a sorted run with repeats, then dedup it
  task automatic sorted_dedup_set();
    int v;
    while (model_len > 0) send_cmd(OP_DEL_POS, '0, 8'd1, '0);
    v = $urandom_range(200) - 100;
    repeat ($urandom_range(1, 12)) begin
      send_cmd(OP_APPEND, v, '0, '0);
      if ($urandom_range(2) != 0) v += $urandom_range(3);
    end
    send_cmd(OP_DEDUP, '0, '0, '0);
    dedup_sets++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    list_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: status %0b count %0d read %h",
                 $time, status_o, element_count_o, read_value_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        checked++;
        if (status_o !== e.status) begin
          $display("%0t: status expected %0b actual %0b", $time, e.status, status_o);
          errors++;
        end
        if (element_count_o !== e.count) begin
          $display("%0t: count expected %0d actual %0d", $time, e.count, element_count_o);
          errors++;
        end
        if (read_value_o !== e.rdval) begin
          $display("%0t: read value expected %h actual %h", $time, e.rdval, read_value_o);
          errors++;
        end
      end
    end
  end

  // result side stall, with one long hold-off once traffic is under way
  always @(posedge clk_i) begin
    int hold_cycles;
    if (!hold_done && sent > 700) begin
      hold_done <= 1'b1;
      hold_cycles = 600;
      out_stall_i <= 1'b1;
      while (hold_cycles > 0) begin
        @(posedge clk_i);
        hold_cycles--;
      end
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < 17);
    end
  end

  initial begin
    #20ms;
    $display("sequential_list_engine regression: fail");
    $finish;
  end

  initial begin
    dir_row_t rows[$];
    op_e      op;
    errors = 0;
    sent = 0;
    checked = 0;
    full_hits = 0;
    dedup_sets = 0;
    quiet = 0;
    hold_done = 0;
    drain_done = 0;
    model_len = 0;
    rows = '{
      '{OP_READ,    32'd0,         8'd1,   16'd0,      1, 1'b1, 8'd0, 32'd0},
      '{OP_DEL_VAL, 32'd5,         8'd0,   16'd0,      1, 1'b1, 8'd0, 32'd0},
      '{OP_DEL_POS, 32'd0,         8'd1,   16'd0,      1, 1'b1, 8'd0, 32'd0},
      '{OP_DEDUP,   32'd0,         8'd0,   16'd0,      1, 1'b1, 8'd0, 32'd0},
      '{OP_REV,     32'd0,         8'd0,   16'd0,      1, 1'b0, 8'd0, 32'd0},
      '{OP_ROT,     32'd0,         8'd0,   16'd5,      1, 1'b1, 8'd0, 32'd0},
      '{OP_BAD,     32'hffff_ffff, 8'hff,  16'hffff,   1, 1'b1, 8'd0, 32'd0},
      '{OP_APPEND,  32'h8000_0000, 8'd0,   16'd0,      1, 1'b0, 8'd1, 32'd0},
      '{OP_APPEND,  32'h7fff_ffff, 8'd0,   16'd0,      1, 1'b0, 8'd2, 32'd0},
      '{OP_APPEND,  32'h7fff_ffff, 8'd0,   16'd0,      1, 1'b0, 8'd3, 32'd0},
      '{OP_READ,    32'd0,         8'd1,   16'd0,      1, 1'b0, 8'd3, 32'h8000_0000},
      '{OP_READ,    32'd0,         8'd3,   16'd0,      1, 1'b0, 8'd3, 32'h7fff_ffff},
      '{OP_READ,    32'd0,         8'd0,   16'd0,      1, 1'b1, 8'd3, 32'd0},
      '{OP_READ,    32'd0,         8'd255, 16'd0,      1, 1'b1, 8'd3, 32'd0},
      '{OP_DEL_POS, 32'd0,         8'd0,   16'd0,      1, 1'b1, 8'd3, 32'd0},
      '{OP_DEL_POS, 32'd0,         8'd4,   16'd0,      1, 1'b1, 8'd3, 32'd0},
      '{OP_DEDUP,   32'd0,         8'd0,   16'd0,      0, 1'b0, 8'd0, 32'd0},
      '{OP_APPEND,  32'd0,         8'd0,   16'd0,      0, 1'b0, 8'd0, 32'd0},
      '{OP_APPEND,  32'hffff_ffff, 8'd0,   16'd0,      0, 1'b0, 8'd0, 32'd0},
      '{OP_ROT,     32'd0,         8'd0,   16'h7fff,   0, 1'b0, 8'd0, 32'd0},
      '{OP_ROT,     32'd0,         8'd0,   16'h8000,   0, 1'b0, 8'd0, 32'd0},
      '{OP_REV,     32'd0,         8'd0,   16'd0,      0, 1'b0, 8'd0, 32'd0},
      '{OP_DEL_VAL, 32'h1234_5678, 8'd0,   16'd0,      0, 1'b0, 8'd0, 32'd0},
      '{OP_DEL_VAL, 32'h7fff_ffff, 8'd0,   16'd0,      0, 1'b0, 8'd0, 32'd0},
      '{OP_DEL_POS, 32'd0,         8'd1,   16'd0,      0, 1'b0, 8'd0, 32'd0}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i])
      send_cmd(rows[i].op, rows[i].value, rows[i].position, rows[i].shift, rows[i].known,
               '{rows[i].status, rows[i].count, rows[i].rdval});

    // fill to capacity and push past it
    while (model_len < DEPTH) send_cmd(OP_APPEND, pick_value(), '0, '0);
    repeat (3) send_cmd(OP_APPEND, $urandom, '0, '0);
    send_cmd(OP_ROT, '0, '0, 16'h8000);
    send_cmd(OP_REV, '0, '0, '0);
    send_cmd(OP_READ, '0, 8'd128, '0);

    while (sent < 1300) begin
      quiet = (sent >= 400 && sent < 550);
      if (sent >= 900 && !drain_done) begin
        drain_done = 1;
        idle_input();
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(19) == 0) begin
        sorted_dedup_set();
      end else begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5, 6: op = OP_APPEND;
          7, 8:   op = OP_DEL_VAL;
          9, 10:  op = OP_DEL_POS;
          11:     op = OP_DEDUP;
          12:     op = OP_REV;
          13, 14: op = OP_ROT;
          15, 16, 17: op = OP_READ;
          18:     op = OP_BAD;
          default: op = (model_len > 60) ? OP_DEL_POS : OP_APPEND;
        endcase
        send_cmd(op, pick_value(), pick_position(), pick_shift());
      end
    end
    quiet = 0;
    idle_input();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (500) @(posedge clk_i);

    $display("%0d commands sent, %0d results checked, %0d full-list appends,",
             sent, checked, full_hits);
    $display("%0d sorted dedup sequences, one long result hold-off", dedup_sets);
    if (errors == 0)
      $display("sequential_list_engine regression: pass");
    else
      $display("sequential_list_engine regression: fail");
    $finish;
  end

endmodule
